// ===== src/id3tfp_pkg.sv =====
// Shared types, constants and frame ID table for the ID3 text frame parser.
// No dependencies; imported by every other file of the block.
package id3tfp_pkg;

    localparam int unsigned HEADER_BYTES        = 10;
    localparam int unsigned ID_BYTES            = 4;
    localparam int unsigned SIZE_BYTES          = 4;
    localparam int unsigned SKIP_BYTES          = 3;
    localparam int unsigned KIND_COUNT          = 6;
    localparam int unsigned KIND_W              = 3;
    localparam int unsigned COUNT_W             = 32;
    localparam logic [2:0]  FRAMES_WANTED_RESET = 3'd6;
    localparam logic [2:0]  FRAMES_CAP          = 3'd7;

    localparam logic [31:0] KIND_IDS [KIND_COUNT] = '{
        32'h5449_5432,  // TIT2
        32'h5459_4552,  // TYER
        32'h5441_4C42,  // TALB
        32'h5450_4531,  // TPE1
        32'h434F_4D4D,  // COMM
        32'h5443_4F4E   // TCON
    };

    localparam logic [0:0] REG_FRAMES_WANTED = 1'b0;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_SIZE,
        PH_SKIP,
        PH_TEXT,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [COUNT_W-1:0]  byte_count;
        logic [31:0]         frame_id;
        logic [31:0]         frame_length;
        logic [KIND_W-1:0]   current_tag;
        logic                tag_matched;
        logic [2:0]          frames_found;
    } parse_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] tag_kind;
        logic [7:0]        text_byte;
        logic              text_valid;
        logic              frame_end;
        logic              all_done;
    } result_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:        PH_HEADER,
        byte_count:   '0,
        frame_id:     '0,
        frame_length: '0,
        current_tag:  '0,
        tag_matched:  1'b0,
        frames_found: '0
    };

endpackage

// ===== src/id3tfp_step.sv =====
// Next-state and result logic for one file byte of the ID3 text frame parser.
// Purely combinational; depends on id3tfp_pkg.
module id3tfp_step
    import id3tfp_pkg::*;
(
    input  parse_state_t cur_state,
    input  logic [7:0]   data_byte,
    input  logic         file_start,
    input  logic [2:0]   frames_wanted,
    output parse_state_t next_state,
    output result_t      result,
    output logic         result_hit
);

    parse_state_t       st;
    parse_state_t       nx;
    result_t            res;
    logic               hit;
    logic [2:0]         lim;
    logic [2:0]         found_inc;
    logic [COUNT_W-1:0] bc_inc;
    logic [COUNT_W-1:0] bc_dec;
    logic [31:0]        id_shift;
    logic               match_any;
    logic [KIND_W-1:0]  match_kind;
    logic               finish_req;

    always_comb begin
        st = file_start ? PARSE_RESET : cur_state;

        // wanted count clamped to 1..6
        if (frames_wanted == 3'd0) begin
            lim = 3'd1;
        end else if (frames_wanted > 3'(KIND_COUNT)) begin
            lim = 3'(KIND_COUNT);
        end else begin
            lim = frames_wanted;
        end
        found_inc = (st.frames_found < FRAMES_CAP) ? st.frames_found + 3'd1
                                                   : st.frames_found;

        bc_inc   = st.byte_count + COUNT_W'(1);
        bc_dec   = st.byte_count - COUNT_W'(1);
        id_shift = {st.frame_id[23:0], data_byte};

        match_any  = 1'b0;
        match_kind = '0;
        for (int k = KIND_COUNT - 1; k >= 0; k--) begin
            if (id_shift == KIND_IDS[k]) begin
                match_any  = 1'b1;
                match_kind = KIND_W'(k);
            end
        end

        nx         = st;
        res        = '0;
        hit        = 1'b0;
        finish_req = 1'b0;

        case (st.phase)
            PH_HEADER: begin
                nx.byte_count = bc_inc;
                if (bc_inc >= COUNT_W'(HEADER_BYTES)) begin
                    nx.phase      = PH_ID;
                    nx.byte_count = '0;
                end
            end
            PH_ID: begin
                nx.frame_id   = id_shift;
                nx.byte_count = bc_inc;
                if (bc_inc >= COUNT_W'(ID_BYTES)) begin
                    nx.tag_matched  = match_any;
                    nx.current_tag  = match_kind;
                    nx.phase        = PH_SIZE;
                    nx.byte_count   = '0;
                    nx.frame_length = '0;
                end
            end
            PH_SIZE: begin
                nx.frame_length = {st.frame_length[23:0], data_byte};
                nx.byte_count   = bc_inc;
                if (bc_inc >= COUNT_W'(SIZE_BYTES)) begin
                    nx.phase      = PH_SKIP;
                    nx.byte_count = '0;
                end
            end
            PH_SKIP: begin
                nx.byte_count = bc_inc;
                if (bc_inc >= COUNT_W'(SKIP_BYTES)) begin
                    if (st.frame_length <= 32'd1) begin
                        if (st.tag_matched) begin
                            hit           = 1'b1;
                            res.tag_kind  = st.current_tag;
                            res.frame_end = 1'b1;
                            finish_req    = 1'b1;
                        end else begin
                            nx.phase      = PH_ID;
                            nx.byte_count = '0;
                        end
                    end else begin
                        nx.phase      = PH_TEXT;
                        nx.byte_count = st.frame_length - 32'd1;
                    end
                end
            end
            PH_TEXT: begin
                nx.byte_count = bc_dec;
                if (st.tag_matched) begin
                    hit            = 1'b1;
                    res.tag_kind   = st.current_tag;
                    res.text_byte  = data_byte;
                    res.text_valid = 1'b1;
                    res.frame_end  = (bc_dec == '0);
                end
                if (bc_dec == '0) begin
                    if (st.tag_matched) begin
                        finish_req = 1'b1;
                    end else begin
                        nx.phase      = PH_ID;
                        nx.byte_count = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        if (finish_req) begin
            nx.frames_found = found_inc;
            if (found_inc >= lim) begin
                nx.phase     = PH_DONE;
                res.all_done = 1'b1;
            end else begin
                nx.phase      = PH_ID;
                nx.byte_count = '0;
            end
        end
    end

    assign next_state = nx;
    assign result     = res;
    assign result_hit = hit;

endmodule

// ===== src/id3_text_frame_parser_unit.sv =====
// Top level of the ID3 text frame parser: parse state, output register, config port.
// Depends on id3tfp_pkg and id3tfp_step.
//
//  channel  dir  handshake                  payload
//  s_       in   s_tvalid / s_tready         s_tdata = data_byte, s_tuser = file_start
//  m_       out  m_tvalid / m_tready         m_tdata = tag_kind, text_byte; m_tlast = frame_end;
//                                            m_tuser = text_valid, all_done
//  apb      in   psel, penable, pwrite       reg 0 at 0x0: frames_wanted
//
//  One file byte per cycle while s_tready is high; the state update and result are one combinational step.
//  A result is registered and appears on m_ in the cycle after its byte is taken.
//  s_tready drops only while a result is held and m_tready is low.
//  aresetn (synchronous, low) returns the parser to the header skip phase,
//  frames_wanted to 6 and empties the output register.
module id3_text_frame_parser_unit
    import id3tfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] file_start

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [2:0] tag_kind, [10:3] text_byte, [15:11] zero
    output logic        m_tlast,
    output logic [1:0]  m_tuser,    // [0] text_valid, [1] all_done

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      step_result;
    logic         step_hit;
    result_t      out_reg;
    logic         out_valid_reg;
    logic [2:0]   frames_wanted_reg;
    logic         s_accept;
    logic         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_FRAMES_WANTED) ? {29'd0, frames_wanted_reg} : 32'd0;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    id3tfp_step u_step (
        .cur_state     (state_reg),
        .data_byte     (s_tdata),
        .file_start    (s_tuser),
        .frames_wanted (frames_wanted_reg),
        .next_state    (state_next),
        .result        (step_result),
        .result_hit    (step_hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_wanted_reg <= FRAMES_WANTED_RESET;
        end else if (cfg_write && paddr[2] == REG_FRAMES_WANTED) begin
            frames_wanted_reg <= pwdata[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PARSE_RESET;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= step_hit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && step_hit) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.text_byte, out_reg.tag_kind};
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = {out_reg.all_done, out_reg.text_valid};

endmodule

// ===== src/id3tfp_checker.sv =====
// Port-level checks for the ID3 text frame parser, bound to the top level.
// Depends on id3tfp_pkg and id3_text_frame_parser_unit.
module id3tfp_checker
    import id3tfp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side only stalls behind a held result
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with output free");

    // completion flag only on a frame end
    a_done_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("all_done without frame_end");

    // empty frame item: zero text, marked as end
    a_empty_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[10:3] == 8'd0)
        else $error("bad empty frame item");

endmodule

bind id3_text_frame_parser_unit id3tfp_checker u_id3tfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/id3_text_frame_parser_unit_tb.sv =====
// Testbench for id3_text_frame_parser_unit: streams ID3 files byte by byte, predicts every
// text item and compares it field by field. Writes frames_wanted over APB between phases.
// Depends on id3tfp_pkg and the block's RTL.
`timescale 1ns / 100ps

module id3_text_frame_parser_unit_tb
    import id3tfp_pkg::*;
();

    class text_frame_scoreboard;
        phase_t            phase;
        logic [31:0]       byte_count;
        logic [31:0]       frame_id;
        logic [31:0]       frame_length;
        logic [KIND_W-1:0] current_tag;
        logic              tag_matched;
        logic [2:0]        frames_found;
        logic [2:0]        frames_wanted;
        result_t           pending_text[$];
        int unsigned       mismatches;
        int unsigned       bytes_taken;
        int unsigned       files_started;
        int unsigned       text_items;
        int unsigned       empty_frames;
        int unsigned       stop_marks;

        function new();
            frames_wanted = FRAMES_WANTED_RESET;
            mismatches    = 0;
            bytes_taken   = 0;
            files_started = 0;
            text_items    = 0;
            empty_frames  = 0;
            stop_marks    = 0;
            restart_file();
        endfunction

        function void restart_file();
            phase        = PH_HEADER;
            byte_count   = '0;
            frame_id     = '0;
            frame_length = '0;
            current_tag  = '0;
            tag_matched  = 1'b0;
            frames_found = '0;
        endfunction

        function bit close_frame();
            int limit;
            limit = frames_wanted;
            if (limit == 0) limit = 1;
            if (limit > KIND_COUNT) limit = KIND_COUNT;
            if (frames_found < FRAMES_CAP) frames_found++;
            if (frames_found >= limit) begin
                phase = PH_DONE;
                return 1'b1;
            end
            phase      = PH_ID;
            byte_count = '0;
            return 1'b0;
        endfunction

        function void take_file_byte(logic [7:0] b, logic file_start);
            result_t r;
            bit      emit;
            bit      found;
            r     = '0;
            emit  = 1'b0;
            found = 1'b0;
            bytes_taken++;
            if (file_start) begin
                restart_file();
                files_started++;
            end
            case (phase)
                PH_HEADER: begin
                    byte_count++;
                    if (byte_count >= HEADER_BYTES) begin
                        phase      = PH_ID;
                        byte_count = '0;
                    end
                end
                PH_ID: begin
                    frame_id = {frame_id[23:0], b};
                    byte_count++;
                    if (byte_count >= ID_BYTES) begin
                        tag_matched = 1'b0;
                        current_tag = '0;
                        for (int k = 0; k < KIND_COUNT; k++) begin
                            if (!found && frame_id == KIND_IDS[k]) begin
                                found       = 1'b1;
                                tag_matched = 1'b1;
                                current_tag = KIND_W'(k);
                            end
                        end
                        phase        = PH_SIZE;
                        byte_count   = '0;
                        frame_length = '0;
                    end
                end
                PH_SIZE: begin
                    frame_length = {frame_length[23:0], b};
                    byte_count++;
                    if (byte_count >= SIZE_BYTES) begin
                        phase      = PH_SKIP;
                        byte_count = '0;
                    end
                end
                PH_SKIP: begin
                    byte_count++;
                    if (byte_count >= SKIP_BYTES) begin
                        if (frame_length <= 1) begin
                            if (tag_matched) begin
                                r.tag_kind  = current_tag;
                                r.frame_end = 1'b1;
                                r.all_done  = close_frame();
                                emit        = 1'b1;
                                empty_frames++;
                            end else begin
                                phase      = PH_ID;
                                byte_count = '0;
                            end
                        end else begin
                            phase      = PH_TEXT;
                            byte_count = frame_length - 1;
                        end
                    end
                end
                PH_TEXT: begin
                    byte_count--;
                    if (tag_matched) begin
                        r.tag_kind   = current_tag;
                        r.text_byte  = b;
                        r.text_valid = 1'b1;
                        r.frame_end  = (byte_count == 0);
                        emit         = 1'b1;
                        text_items++;
                    end
                    if (byte_count == 0) begin
                        if (tag_matched) begin
                            r.all_done = close_frame();
                        end else begin
                            phase      = PH_ID;
                            byte_count = '0;
                        end
                    end
                end
                default: ;
            endcase
            if (emit) begin
                if (r.all_done) stop_marks++;
                pending_text.push_back(r);
            end
        endfunction

        function void check_text_item(result_t got);
            result_t want;
            if (pending_text.size() == 0) begin
                $error("unexpected item: tag_kind %0d text_byte %02h", got.tag_kind,
                       got.text_byte);
                mismatches++;
                return;
            end
            want = pending_text.pop_front();
            if (got.tag_kind !== want.tag_kind) begin
                $error("tag_kind: expected %0d, got %0d", want.tag_kind, got.tag_kind);
                mismatches++;
            end
            if (got.text_byte !== want.text_byte) begin
                $error("text_byte: expected %02h, got %02h", want.text_byte, got.text_byte);
                mismatches++;
            end
            if (got.text_valid !== want.text_valid) begin
                $error("text_valid: expected %0b, got %0b", want.text_valid, got.text_valid);
                mismatches++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
                mismatches++;
            end
            if (got.all_done !== want.all_done) begin
                $error("all_done: expected %0b, got %0b", want.all_done, got.all_done);
                mismatches++;
            end
        endfunction
    endclass

    localparam logic [31:0] UNKNOWN_ID = 32'h5858_5858;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    text_frame_scoreboard sb;
    bit send_burst;
    bit recv_burst;

    id3_text_frame_parser_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready) begin
            sb.check_text_item('{tag_kind:   m_tdata[2:0],
                                 text_byte:  m_tdata[10:3],
                                 text_valid: m_tuser[0],
                                 frame_end:  m_tlast,
                                 all_done:   m_tuser[1]});
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic file_start);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= file_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_file_byte(b, file_start);
    endtask

    task automatic start_file();
        send_byte(8'($urandom), 1'b1);
        repeat (HEADER_BYTES - 1) send_byte(8'($urandom), 1'b0);
    endtask

    // max_text caps the text bytes sent; a lower cap cuts the frame short
    task automatic send_frame(input logic [31:0] id, input logic [31:0] size,
                              input int unsigned max_text);
        int unsigned n;
        n = 0;
        if (size > 1) n = (size - 1 < max_text) ? size - 1 : max_text;
        for (int i = ID_BYTES - 1; i >= 0; i--) send_byte(id[8*i +: 8], 1'b0);
        for (int i = SIZE_BYTES - 1; i >= 0; i--) send_byte(size[8*i +: 8], 1'b0);
        repeat (SKIP_BYTES) send_byte(8'($urandom), 1'b0);
        repeat (n) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_text.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_frames_wanted(input logic [2:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRAMES_WANTED, 2'b00};
        pwdata  <= {29'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.frames_wanted = value;
    endtask

    function automatic logic [31:0] pick_frame_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return KIND_IDS[$urandom_range(0, KIND_COUNT - 1)];
        if (r == 7) return KIND_IDS[$urandom_range(0, KIND_COUNT - 1)] ^
                           (32'h1 << $urandom_range(0, 31));
        if (r == 8) return 32'h0;
        return $urandom;
    endfunction

    task automatic random_file();
        int          n_frames;
        int          r;
        logic [31:0] size;
        send_burst = ($urandom_range(0, 3) == 0);
        n_frames   = $urandom_range(1, 9);
        start_file();
        for (int i = 0; i < n_frames; i++) begin
            if ($urandom_range(0, 24) == 0) begin
                settle();
                write_frames_wanted(3'($urandom_range(0, 7)));
            end
            r = $urandom_range(0, 19);
            if (r < 2) size = 32'(r);
            else if (r < 17) size = $urandom_range(2, 9);
            else if (r < 19) size = $urandom_range(10, 40);
            else size = {8'($urandom_range(1, 255)), 24'($urandom)};
            if (r == 19 || $urandom_range(0, 14) == 0) begin
                send_frame(pick_frame_id(), size, $urandom_range(0, 6));
                return;
            end
            send_frame(pick_frame_id(), size, 64);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        int unsigned directed_bytes;
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        send_burst = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // parser runs from reset without a file_start
        repeat (HEADER_BYTES) send_byte(8'($urandom), 1'b0);
        send_frame(KIND_IDS[0], 32'd3, 64);

        // empty frames, every kind, unknown frame, stop at six, ignored tail
        send_burst = 1'b1;
        start_file();
        send_frame(KIND_IDS[1], 32'd1, 64);
        send_frame(KIND_IDS[2], 32'd0, 64);
        send_frame(UNKNOWN_ID, 32'd3, 64);
        send_frame(KIND_IDS[3], 32'd2, 64);
        send_frame(KIND_IDS[4], 32'd2, 64);
        send_frame(KIND_IDS[5], 32'd2, 64);
        send_frame(KIND_IDS[0], 32'd2, 64);
        send_frame(KIND_IDS[1], 32'd2, 64);
        send_burst = 1'b0;

        settle();
        write_frames_wanted(3'd0);
        start_file();
        send_frame(UNKNOWN_ID, 32'd0, 64);
        send_frame(KIND_IDS[0], 32'd2, 64);
        send_frame(KIND_IDS[1], 32'd2, 64);

        settle();
        write_frames_wanted(3'd7);
        start_file();
        for (int k = 0; k < KIND_COUNT + 1; k++) send_frame(KIND_IDS[k % KIND_COUNT], 32'd2, 64);

        // count lowered below frames already found
        settle();
        write_frames_wanted(3'd6);
        start_file();
        send_frame(KIND_IDS[0], 32'd2, 64);
        send_frame(KIND_IDS[1], 32'd2, 64);
        settle();
        write_frames_wanted(3'd1);
        send_frame(KIND_IDS[2], 32'd2, 64);

        settle();
        write_frames_wanted(3'd6);
        start_file();
        send_frame(KIND_IDS[3], 32'hFFFF_FFFF, 5);
        directed_bytes = sb.bytes_taken;

        // random files top the run up to about 600 bytes
        while (sb.bytes_taken < directed_bytes + 260) begin
            random_file();
            if ($urandom_range(0, 3) == 0) begin
                settle();
                write_frames_wanted(3'($urandom_range(0, 7)));
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        $display("Ran %0d files, %0d bytes: %0d text items, %0d empty frames, %0d stop marks,",
                 sb.files_started, sb.bytes_taken, sb.text_items, sb.empty_frames,
                 sb.stop_marks);
        $display("with frames_wanted swept over 0..7 and random stalls on both sides.");
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        int stall;
        recv_burst = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d items still expected.", sb.pending_text.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/id3tfp_pkg.sv
src/id3tfp_step.sv
src/id3_text_frame_parser_unit.sv
src/id3tfp_checker.sv
tb/id3_text_frame_parser_unit_tb.sv
